// ===== rtl/vsrt_pkg.sv =====
// Shared types, register map, reset values and saturation helper for the vertex transform.
package vsrt_pkg;

	// Configuration port geometry: eight registers on an eight-byte pitch.
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef logic [2:0] reg_idx_t;

	// Register index codes.
	localparam reg_idx_t REG_SCALE_X  = 3'd0;
	localparam reg_idx_t REG_SCALE_Y  = 3'd1;
	localparam reg_idx_t REG_SCALE_Z  = 3'd2;
	localparam reg_idx_t REG_OFFSET_X = 3'd3;
	localparam reg_idx_t REG_OFFSET_Y = 3'd4;
	localparam reg_idx_t REG_OFFSET_Z = 3'd5;
	localparam reg_idx_t REG_ROT_COS  = 3'd6;
	localparam reg_idx_t REG_ROT_SIN  = 3'd7;

	// Rounding constants: one half LSB after the scale and rotate shifts.
	localparam logic signed [63:0] SCALE_RND = 64'sd32768;
	localparam logic signed [49:0] ROT_RND   = 50'sd8192;

	// Q16.16 limits.
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// Input word.
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} vtx_in_t;

	// Result word.
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} vtx_out_t;

	// Internal coordinate triple.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	// Live configuration as seen by the datapath.
	typedef struct packed {
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic [47:0]        rot_cos;
		logic [47:0]        rot_sin;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		scale_x:  32'sd65536,
		scale_y:  32'sd65536,
		scale_z:  32'sd65536,
		offset_x: 32'sd0,
		offset_y: 32'sd0,
		offset_z: 32'sd0,
		rot_cos:  48'h4000_4000_4000,
		rot_sin:  48'h0
	};

	// Clamp a 48-bit signed value to the 32-bit Q16.16 range.
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic all_same;
		all_same = (v[47:31] == {17{1'b0}}) || (v[47:31] == {17{1'b1}});
		if (all_same) begin
			return v[31:0];
		end else if (v[47]) begin
			return Q_MIN;
		end else begin
			return Q_MAX;
		end
	endfunction

endpackage

// ===== rtl/vsrt_cfg.sv =====
// Configuration register file with a 64-bit APB-style access port.
module vsrt_cfg
	import vsrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Register writes; bits above a register's width are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_SCALE_X:  cfg_q.scale_x  <= pwdata[31:0];
				REG_SCALE_Y:  cfg_q.scale_y  <= pwdata[31:0];
				REG_SCALE_Z:  cfg_q.scale_z  <= pwdata[31:0];
				REG_OFFSET_X: cfg_q.offset_x <= pwdata[31:0];
				REG_OFFSET_Y: cfg_q.offset_y <= pwdata[31:0];
				REG_OFFSET_Z: cfg_q.offset_z <= pwdata[31:0];
				REG_ROT_COS:  cfg_q.rot_cos  <= pwdata[47:0];
				REG_ROT_SIN:  cfg_q.rot_sin  <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Read-back mux, zero-extended to the bus width.
	always_comb begin
		unique case (idx)
			REG_SCALE_X:  prdata = {32'h0, cfg_q.scale_x};
			REG_SCALE_Y:  prdata = {32'h0, cfg_q.scale_y};
			REG_SCALE_Z:  prdata = {32'h0, cfg_q.scale_z};
			REG_OFFSET_X: prdata = {32'h0, cfg_q.offset_x};
			REG_OFFSET_Y: prdata = {32'h0, cfg_q.offset_y};
			REG_OFFSET_Z: prdata = {32'h0, cfg_q.offset_z};
			REG_ROT_COS:  prdata = {16'h0, cfg_q.rot_cos};
			REG_ROT_SIN:  prdata = {16'h0, cfg_q.rot_sin};
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/vsrt_scale.sv =====
// Two-stage per-axis scaler: 32x32 multiply, then round half up and saturate.
module vsrt_scale
	import vsrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  vec_t               vec_in,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	output logic               valid_out,
	output vec_t               vec_out
);

	logic               valid_s1;
	logic               valid_s2;
	logic signed [63:0] prod_x_s1;
	logic signed [63:0] prod_y_s1;
	logic signed [63:0] prod_z_s1;
	vec_t               vec_s2;
	logic signed [63:0] rnd_x;
	logic signed [63:0] rnd_y;
	logic signed [63:0] rnd_z;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: full-width products.
	always_ff @(posedge clk) begin
		prod_x_s1 <= vec_in.x * scale_x;
		prod_y_s1 <= vec_in.y * scale_y;
		prod_z_s1 <= vec_in.z * scale_z;
	end

	// Add one half LSB; the arithmetic shift by 16 is the upper part-select.
	assign rnd_x = prod_x_s1 + SCALE_RND;
	assign rnd_y = prod_y_s1 + SCALE_RND;
	assign rnd_z = prod_z_s1 + SCALE_RND;

	// Stage 2: rounded and saturated Q16.16.
	always_ff @(posedge clk) begin
		vec_s2.x <= sat32(rnd_x[63:16]);
		vec_s2.y <= sat32(rnd_y[63:16]);
		vec_s2.z <= sat32(rnd_z[63:16]);
	end

	assign valid_out = valid_s2;
	assign vec_out   = vec_s2;

endmodule

// ===== rtl/vsrt_rot.sv =====
// Two-stage planar rotation: a' = a*c - b*s, b' = a*s + b*c, third axis carried along.
module vsrt_rot
	import vsrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] pass,
	input  logic signed [15:0] cos_v,
	input  logic signed [15:0] sin_v,
	output logic               valid_out,
	output logic signed [31:0] a_out,
	output logic signed [31:0] b_out,
	output logic signed [31:0] pass_out
);

	logic               valid_s1;
	logic               valid_s2;
	logic signed [47:0] p_ac_s1;
	logic signed [47:0] p_bs_s1;
	logic signed [47:0] p_as_s1;
	logic signed [47:0] p_bc_s1;
	logic signed [31:0] pass_s1;
	logic signed [31:0] a_s2;
	logic signed [31:0] b_s2;
	logic signed [31:0] pass_s2;
	logic signed [49:0] sum_a;
	logic signed [49:0] sum_b;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: four 32x16 products.
	always_ff @(posedge clk) begin
		p_ac_s1 <= a * cos_v;
		p_bs_s1 <= b * sin_v;
		p_as_s1 <= a * sin_v;
		p_bc_s1 <= b * cos_v;
		pass_s1 <= pass;
	end

	// Combine with one half LSB of rounding before the shift by 14.
	assign sum_a = $signed({{2{p_ac_s1[47]}}, p_ac_s1})
		- $signed({{2{p_bs_s1[47]}}, p_bs_s1}) + ROT_RND;
	assign sum_b = $signed({{2{p_as_s1[47]}}, p_as_s1})
		+ $signed({{2{p_bc_s1[47]}}, p_bc_s1}) + ROT_RND;

	// Stage 2: shift, saturate.
	always_ff @(posedge clk) begin
		a_s2    <= sat32($signed({{12{sum_a[49]}}, sum_a[49:14]}));
		b_s2    <= sat32($signed({{12{sum_b[49]}}, sum_b[49:14]}));
		pass_s2 <= pass_s1;
	end

	assign valid_out = valid_s2;
	assign a_out     = a_s2;
	assign b_out     = b_s2;
	assign pass_out  = pass_s2;

endmodule

// ===== rtl/vertex_scale_rotate_translate.sv =====
// Top level of the vertex transform: scale, rotate about X, Y and Z, translate.
//
// Usage:
// - Input channel: a vertex word (pos_x, pos_y, pos_z, signed Q16.16) is taken
//   at each rising edge where start is high and busy is low. busy never rises,
//   so a new word may enter on every clock.
// - Output channel: done is high for exactly one cycle with the transformed
//   word on result; the receiver must take it in that cycle.
// - From the accepting edge to the edge at which the result is taken, a word
//   passes two stages that scale (multiply, round), two stages for each of
//   the three rotations (multiply, combine) and one stage that translates.
// - Throughput is one word per clock, set by the fully pipelined multipliers.
// - Configuration goes through the APB-style port, registers on an 8-byte
//   pitch; write it only while no word is in flight.
// - Reset clears all valid bits, so no word survives it, and puts scale 1.0,
//   offset 0, cosines 1.0 and sines 0 in the registers.
module vertex_scale_rotate_translate
	import vsrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  vtx_in_t           vertex,
	output logic              done,
	output vtx_out_t          result
);

	cfg_t               cfg;
	vec_t               vin;
	logic               sc_valid;
	vec_t               sc_vec;
	logic               rx_valid;
	logic signed [31:0] rx_y;
	logic signed [31:0] rx_z;
	logic signed [31:0] rx_x;
	logic               ry_valid;
	logic signed [31:0] ry_x;
	logic signed [31:0] ry_z;
	logic signed [31:0] ry_y;
	logic               rz_valid;
	logic signed [31:0] rz_x;
	logic signed [31:0] rz_y;
	logic signed [31:0] rz_z;
	logic signed [32:0] sum_x;
	logic signed [32:0] sum_y;
	logic signed [32:0] sum_z;
	logic               done_s1;
	vtx_out_t           res_s1;

	// The pipeline never stalls.
	assign busy = 1'b0;

	assign vin.x = vertex.pos_x;
	assign vin.y = vertex.pos_y;
	assign vin.z = vertex.pos_z;

	vsrt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vsrt_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (start && !busy),
		.vec_in    (vin),
		.scale_x   (cfg.scale_x),
		.scale_y   (cfg.scale_y),
		.scale_z   (cfg.scale_z),
		.valid_out (sc_valid),
		.vec_out   (sc_vec)
	);

	// Rotation about X turns the Y-Z plane.
	vsrt_rot u_rot_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (sc_valid),
		.a         (sc_vec.y),
		.b         (sc_vec.z),
		.pass      (sc_vec.x),
		.cos_v     (cfg.rot_cos[15:0]),
		.sin_v     (cfg.rot_sin[15:0]),
		.valid_out (rx_valid),
		.a_out     (rx_y),
		.b_out     (rx_z),
		.pass_out  (rx_x)
	);

	// Rotation about Y turns the X-Z plane.
	vsrt_rot u_rot_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (rx_valid),
		.a         (rx_x),
		.b         (rx_z),
		.pass      (rx_y),
		.cos_v     (cfg.rot_cos[31:16]),
		.sin_v     (cfg.rot_sin[31:16]),
		.valid_out (ry_valid),
		.a_out     (ry_x),
		.b_out     (ry_z),
		.pass_out  (ry_y)
	);

	// Rotation about Z turns the X-Y plane.
	vsrt_rot u_rot_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (ry_valid),
		.a         (ry_x),
		.b         (ry_y),
		.pass      (ry_z),
		.cos_v     (cfg.rot_cos[47:32]),
		.sin_v     (cfg.rot_sin[47:32]),
		.valid_out (rz_valid),
		.a_out     (rz_x),
		.b_out     (rz_y),
		.pass_out  (rz_z)
	);

	// Translation sums, one bit wider to catch overflow.
	assign sum_x = $signed({rz_x[31], rz_x}) + $signed({cfg.offset_x[31], cfg.offset_x});
	assign sum_y = $signed({rz_y[31], rz_y}) + $signed({cfg.offset_y[31], cfg.offset_y});
	assign sum_z = $signed({rz_z[31], rz_z}) + $signed({cfg.offset_z[31], cfg.offset_z});

	// Output stage: valid strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= rz_valid;
		end
	end

	// Output stage: saturated result word.
	always_ff @(posedge clk) begin
		res_s1.out_x <= sat32($signed({{15{sum_x[32]}}, sum_x}));
		res_s1.out_y <= sat32($signed({{15{sum_y[32]}}, sum_y}));
		res_s1.out_z <= sat32($signed({{15{sum_z[32]}}, sum_z}));
	end

	assign done   = done_s1;
	assign result = res_s1;

endmodule
